// ===== sv/five_stage_pipeline_cpu_core_assert.svh =====
// Assertion shorthands for the core, clocked on clk_i, disabled in reset.
`ifndef FIVE_STAGE_PIPELINE_CPU_CORE_ASSERT_SVH
`define FIVE_STAGE_PIPELINE_CPU_CORE_ASSERT_SVH

`define FSPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("core assertion failed");

`define FSPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("core assertion failed");

`endif

// ===== sv/fspc_pkg.sv =====
package fspc_pkg;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_NOR  = 3'd1;
  localparam logic [2:0] OP_LW   = 3'd2;
  localparam logic [2:0] OP_SW   = 3'd3;
  localparam logic [2:0] OP_BEQ  = 3'd4;
  localparam logic [2:0] OP_JALR = 3'd5;
  localparam logic [2:0] OP_HALT = 3'd6;

  localparam logic [31:0] NOOP_WORD = 32'h01c0_0000;

  typedef struct packed {
    logic [31:0] instr;
    logic [15:0] pc1;
  } ifid_t;

  typedef struct packed {
    logic [31:0] instr;
    logic [15:0] pc1;
    logic [31:0] ra;
    logic [31:0] rb;
    logic [15:0] off;
  } idex_t;

  typedef struct packed {
    logic [31:0] instr;
    logic [15:0] target;
    logic [31:0] alu;
    logic [31:0] rb;
  } exmem_t;

  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] wd;
  } wb_t;

  function automatic logic [2:0] opc(input logic [31:0] w);
    opc = w[24:22];
  endfunction

  function automatic logic [2:0] fld_a(input logic [31:0] w);
    fld_a = w[21:19];
  endfunction

  function automatic logic [2:0] fld_b(input logic [31:0] w);
    fld_b = w[18:16];
  endfunction

  function automatic logic writes_reg(input logic [31:0] w);
    writes_reg = (opc(w) == OP_ADD) || (opc(w) == OP_NOR) || (opc(w) == OP_LW);
  endfunction

  function automatic logic [2:0] dest(input logic [31:0] w);
    dest = (opc(w) == OP_LW) ? w[18:16] : w[2:0];
  endfunction

endpackage

// ===== sv/fspc_ram.sv =====
module fspc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_o <= wdata_i;
      end else begin
        rdata_o <= mem_q[raddr_i];
      end
    end
  end

endmodule

// ===== sv/five_stage_pipeline_cpu_core.sv =====
// Five-stage in-order core for an eight-register 32-bit instruction set.
// Input channel (in_valid_i/in_ready_o) carries requests: req_type_i 0 writes
// data_i into the instruction and data stores at addr_i, 1 runs one machine
// cycle of the pipeline, 2 reads the data store word at addr_i.
// Output channel (out_valid_o/out_ready_i) returns one result per request:
// core status, the register write and store of the cycle, and read data.
// out_valid_o rises in the cycle after acceptance. Throughput is one
// request per clock: the instruction word at the pc and the data word at the
// EX/MEM address are prefetched into the registered read ports of the stores
// each clock from the next-state values, so a step finds them ready.
// A read request uses a separate replica of the data store.
// The output register frees as it is taken; while out_ready_i is low and a
// result waits, in_ready_o drops and requests hold.
// Reset clears the pc, latches (to noop), register file, cycle count and
// status; the store contents are undefined until written by load requests.
// Once halted, step requests change nothing; load and read still work.
module five_stage_pipeline_cpu_core #(
  parameter int MEM_WORDS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        addr_i,
  input  logic signed [31:0] data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               halted_o,
  output logic               fault_o,
  output logic [15:0]        pc_now_o,
  output logic [31:0]        cycle_count_o,
  output logic               reg_write_valid_o,
  output logic [2:0]         reg_write_index_o,
  output logic signed [31:0] reg_write_value_o,
  output logic               mem_write_valid_o,
  output logic [15:0]        mem_write_addr_o,
  output logic signed [31:0] mem_write_value_o,
  output logic signed [31:0] read_data_o
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam bit MEM_POW2 = (MEM_WORDS == (1 << AW));
  localparam longint unsigned RECIP = ((64'd1 << 32) + MEM_WORDS - 1) / MEM_WORDS;

  function automatic logic [AW-1:0] midx(input logic [15:0] a);
    logic [47:0] prod;
    logic [15:0] q;
    logic [31:0] r;
    prod = 48'(a) * 48'(RECIP);
    q = prod[47:32];
    r = 32'(a) - 32'(q) * 32'(MEM_WORDS);
    if (MEM_POW2) begin
      midx = a[AW-1:0];
    end else begin
      midx = r[AW-1:0];
    end
  endfunction

  logic in_fire, load_fire, step_fire, stopped_step, read_fire;
  logic [15:0] pc_q, pc_d;
  fspc_pkg::ifid_t ifid_q, ifid_d;
  fspc_pkg::idex_t idex_q, idex_d;
  fspc_pkg::exmem_t exmem_q, exmem_d;
  fspc_pkg::wb_t memwb_q, memwb_d, wbend_q, wbend_d;
  logic [31:0] regs_q [8];
  logic [31:0] cycles_q, cycles_d;
  logic halted_q, halted_d, fault_q, fault_d;

  logic [31:0] instr_rd, dmem_rd, rdport_rd;
  logic stall, taken, wb_we, sw_we;
  logic [2:0] wb_idx;
  logic [31:0] op_a, op_b;
  logic [2:0] ex_op, mem_op;

  logic dram_we;
  logic [AW-1:0] dram_waddr, iram_raddr, dram_raddr;
  logic [31:0] dram_wdata;

  logic out_valid_q, is_read_q;
  logic rwv_q, mwv_q;
  logic [2:0] rwi_q;
  logic [31:0] rwval_q, mwval_q;
  logic [15:0] mwa_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire = in_valid_i && in_ready_o;
  assign load_fire = in_fire && (req_type_i == fspc_pkg::REQ_LOAD);
  assign stopped_step = in_fire && (req_type_i == fspc_pkg::REQ_STEP);
  assign step_fire = stopped_step && !halted_q;
  assign read_fire = in_fire && (req_type_i == fspc_pkg::REQ_READ);

  always_comb begin
    ifid_d = ifid_q;
    idex_d = idex_q;
    exmem_d = exmem_q;
    memwb_d = memwb_q;
    wbend_d = wbend_q;
    pc_d = pc_q;
    cycles_d = cycles_q;
    halted_d = halted_q;
    fault_d = fault_q;

    ex_op = fspc_pkg::opc(idex_q.instr);
    mem_op = fspc_pkg::opc(exmem_q.instr);

    stall = 1'b0;
    if (fspc_pkg::opc(idex_q.instr) == fspc_pkg::OP_LW) begin
      priority case (fspc_pkg::opc(ifid_q.instr))
        fspc_pkg::OP_ADD, fspc_pkg::OP_NOR, fspc_pkg::OP_BEQ, fspc_pkg::OP_SW:
          stall = (fspc_pkg::fld_a(ifid_q.instr) == fspc_pkg::fld_b(idex_q.instr)) ||
                  (fspc_pkg::fld_b(ifid_q.instr) == fspc_pkg::fld_b(idex_q.instr));
        fspc_pkg::OP_LW:
          stall = fspc_pkg::fld_a(ifid_q.instr) == fspc_pkg::fld_b(idex_q.instr);
        default: stall = 1'b0;
      endcase
    end

    op_a = idex_q.ra;
    op_b = idex_q.rb;
    if (fspc_pkg::writes_reg(wbend_q.instr)) begin
      if (fspc_pkg::fld_a(idex_q.instr) == fspc_pkg::dest(wbend_q.instr)) op_a = wbend_q.wd;
      if (fspc_pkg::fld_b(idex_q.instr) == fspc_pkg::dest(wbend_q.instr)) op_b = wbend_q.wd;
    end
    if (fspc_pkg::writes_reg(memwb_q.instr)) begin
      if (fspc_pkg::fld_a(idex_q.instr) == fspc_pkg::dest(memwb_q.instr)) op_a = memwb_q.wd;
      if (fspc_pkg::fld_b(idex_q.instr) == fspc_pkg::dest(memwb_q.instr)) op_b = memwb_q.wd;
    end
    if ((mem_op == fspc_pkg::OP_ADD) || (mem_op == fspc_pkg::OP_NOR)) begin
      if (fspc_pkg::fld_a(idex_q.instr) == exmem_q.instr[2:0]) op_a = exmem_q.alu;
      if (fspc_pkg::fld_b(idex_q.instr) == exmem_q.instr[2:0]) op_b = exmem_q.alu;
    end

    taken = (mem_op == fspc_pkg::OP_BEQ) && (exmem_q.alu == 32'd0);
    sw_we = mem_op == fspc_pkg::OP_SW;
    wb_we = fspc_pkg::writes_reg(memwb_q.instr);
    wb_idx = fspc_pkg::dest(memwb_q.instr);

    if (step_fire) begin
      if (stall) begin
        idex_d = '{instr: fspc_pkg::NOOP_WORD, default: '0};
      end else begin
        ifid_d.instr = instr_rd;
        ifid_d.pc1 = pc_q + 16'd1;
        pc_d = pc_q + 16'd1;
        idex_d.instr = ifid_q.instr;
        idex_d.pc1 = ifid_q.pc1;
        idex_d.ra = regs_q[fspc_pkg::fld_a(ifid_q.instr)];
        idex_d.rb = regs_q[fspc_pkg::fld_b(ifid_q.instr)];
        idex_d.off = ifid_q.instr[15:0];
      end

      exmem_d.instr = idex_q.instr;
      exmem_d.target = idex_q.pc1 + idex_q.off;
      exmem_d.rb = op_b;
      unique case (ex_op)
        fspc_pkg::OP_ADD: exmem_d.alu = op_a + op_b;
        fspc_pkg::OP_NOR: exmem_d.alu = ~(op_a | op_b);
        fspc_pkg::OP_LW, fspc_pkg::OP_SW:
          exmem_d.alu = op_a + {{16{idex_q.off[15]}}, idex_q.off};
        fspc_pkg::OP_BEQ: exmem_d.alu = op_a - op_b;
        default: exmem_d.alu = 32'd0;
      endcase

      memwb_d.instr = exmem_q.instr;
      unique case (mem_op)
        fspc_pkg::OP_ADD, fspc_pkg::OP_NOR: memwb_d.wd = exmem_q.alu;
        fspc_pkg::OP_LW: memwb_d.wd = dmem_rd;
        default: memwb_d.wd = memwb_q.wd;
      endcase

      if (taken) begin
        pc_d = exmem_q.target;
        ifid_d = '{instr: fspc_pkg::NOOP_WORD, default: '0};
        idex_d = '{instr: fspc_pkg::NOOP_WORD, default: '0};
        exmem_d = '{instr: fspc_pkg::NOOP_WORD, default: '0};
      end

      wbend_d = memwb_q;
      cycles_d = cycles_q + 32'd1;
      if (fspc_pkg::opc(memwb_d.instr) == fspc_pkg::OP_HALT) halted_d = 1'b1;
      if (fspc_pkg::opc(memwb_d.instr) == fspc_pkg::OP_JALR) begin
        halted_d = 1'b1;
        fault_d = 1'b1;
      end
    end
  end

  assign iram_raddr = midx(pc_d);
  assign dram_raddr = midx(exmem_d.alu[15:0]);
  assign dram_we = load_fire || (step_fire && sw_we);
  assign dram_waddr = load_fire ? midx(addr_i) : midx(exmem_q.alu[15:0]);
  assign dram_wdata = load_fire ? data_i : exmem_q.rb;

  fspc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_instr_ram (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (midx(addr_i)),
    .wdata_i (data_i),
    .re_i    (1'b1),
    .raddr_i (iram_raddr),
    .rdata_o (instr_rd)
  );

  fspc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dram_we),
    .waddr_i (dram_waddr),
    .wdata_i (dram_wdata),
    .re_i    (1'b1),
    .raddr_i (dram_raddr),
    .rdata_o (dmem_rd)
  );

  fspc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_data_rd_ram (
    .clk_i   (clk_i),
    .we_i    (dram_we),
    .waddr_i (dram_waddr),
    .wdata_i (dram_wdata),
    .re_i    (read_fire),
    .raddr_i (midx(addr_i)),
    .rdata_o (rdport_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      ifid_q <= '{instr: fspc_pkg::NOOP_WORD, default: '0};
      idex_q <= '{instr: fspc_pkg::NOOP_WORD, default: '0};
      exmem_q <= '{instr: fspc_pkg::NOOP_WORD, default: '0};
      memwb_q <= '{instr: fspc_pkg::NOOP_WORD, default: '0};
      wbend_q <= '{instr: fspc_pkg::NOOP_WORD, default: '0};
      cycles_q <= '0;
      halted_q <= 1'b0;
      fault_q <= 1'b0;
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
    end else begin
      pc_q <= pc_d;
      ifid_q <= ifid_d;
      idex_q <= idex_d;
      exmem_q <= exmem_d;
      memwb_q <= memwb_d;
      wbend_q <= wbend_d;
      cycles_q <= cycles_d;
      halted_q <= halted_d;
      fault_q <= fault_d;
      if (step_fire && wb_we) regs_q[wb_idx] <= memwb_q.wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      is_read_q <= read_fire;
      rwv_q <= step_fire && wb_we;
      rwi_q <= (step_fire && wb_we) ? wb_idx : 3'd0;
      rwval_q <= (step_fire && wb_we) ? memwb_q.wd : 32'd0;
      mwv_q <= step_fire && sw_we;
      mwa_q <= (step_fire && sw_we) ? 16'(midx(exmem_q.alu[15:0])) : 16'd0;
      mwval_q <= (step_fire && sw_we) ? exmem_q.rb : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign halted_o = halted_q;
  assign fault_o = fault_q;
  assign pc_now_o = pc_q;
  assign cycle_count_o = cycles_q;
  assign reg_write_valid_o = rwv_q;
  assign reg_write_index_o = rwi_q;
  assign reg_write_value_o = rwval_q;
  assign mem_write_valid_o = mwv_q;
  assign mem_write_addr_o = mwa_q;
  assign mem_write_value_o = mwval_q;
  assign read_data_o = is_read_q ? rdport_rd : 32'd0;

`include "five_stage_pipeline_cpu_core_assert.svh"

  `FSPC_ASSERT_IMP(a_fault_halts, fault_q, halted_q)
  `FSPC_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q)
  `FSPC_ASSERT_NEXT(a_stopped_pc_holds, halted_q && stopped_step, $stable(pc_q))

endmodule

// ===== test/five_stage_pipeline_cpu_core_checker.sv =====
module five_stage_pipeline_cpu_core_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        addr_i,
  input  logic signed [31:0] data_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               halted_o,
  input  logic               fault_o,
  input  logic [15:0]        pc_now_o,
  input  logic [31:0]        cycle_count_o,
  input  logic               reg_write_valid_o,
  input  logic [2:0]         reg_write_index_o,
  input  logic signed [31:0] reg_write_value_o,
  input  logic               mem_write_valid_o,
  input  logic [15:0]        mem_write_addr_o,
  input  logic signed [31:0] mem_write_value_o,
  input  logic signed [31:0] read_data_o,
  output int                 fail_count_o,
  output int                 open_count_o
);

  typedef struct packed {
    logic        halted;
    logic        fault;
    logic [15:0] pc;
    logic [31:0] cycles;
    logic        rw_valid;
    logic [2:0]  rw_index;
    logic [31:0] rw_value;
    logic        mw_valid;
    logic [15:0] mw_addr;
    logic [31:0] mw_value;
    logic [31:0] rd_data;
  } core_status_t;

  core_status_t status_q[$];

  logic [31:0] imem [0:65535];
  logic [31:0] dmem [0:65535];
  logic [31:0] gpr [0:7];
  logic [15:0] pc;
  logic [31:0] fd_instr;
  logic [15:0] fd_pc1;
  logic [31:0] de_instr, de_ra, de_rb, de_off;
  logic [15:0] de_pc1;
  logic [31:0] em_instr, em_alu, em_rb;
  logic [15:0] em_target;
  logic [31:0] mw_instr, mw_wd, we_instr, we_wd;
  logic [31:0] cycles;
  logic        stopped, faulted;

  assign open_count_o = status_q.size();

  function automatic bit dest_of(input logic [31:0] w, output logic [2:0] d);
    d = 3'd0;
    case (w[24:22])
      fspc_pkg::OP_ADD, fspc_pkg::OP_NOR: begin
        d = w[2:0];
        return 1'b1;
      end
      fspc_pkg::OP_LW: begin
        d = w[18:16];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void bypass(input logic [31:0] src, val, ins,
                                 inout logic [31:0] a, b);
    logic [2:0] d;
    if (dest_of(src, d)) begin
      if (ins[21:19] == d) a = val;
      if (ins[18:16] == d) b = val;
    end
  endfunction

  function automatic bit load_hazard();
    logic [2:0] cur, ld;
    cur = fd_instr[24:22];
    ld = de_instr[18:16];
    if (de_instr[24:22] != fspc_pkg::OP_LW) return 1'b0;
    if (cur == fspc_pkg::OP_ADD || cur == fspc_pkg::OP_NOR || cur == fspc_pkg::OP_BEQ ||
        cur == fspc_pkg::OP_SW)
      return fd_instr[21:19] == ld || fd_instr[18:16] == ld;
    if (cur == fspc_pkg::OP_LW) return fd_instr[21:19] == ld;
    return 1'b0;
  endfunction

  task automatic advance_pipeline(inout core_status_t r);
    logic [15:0] npc, nfd_pc1, nde_pc1, nem_target;
    logic [31:0] nfd_instr, nde_instr, nde_ra, nde_rb, nde_off;
    logic [31:0] nem_instr, nem_alu, nem_rb, nmw_instr, nmw_wd;
    logic [31:0] a, b;
    logic [2:0]  op, d;
    npc = pc + 16'd1;
    nfd_instr = imem[pc];
    nfd_pc1 = npc;
    if (load_hazard()) begin
      npc = pc;
      nfd_instr = fd_instr;
      nfd_pc1 = fd_pc1;
      nde_instr = fspc_pkg::NOOP_WORD;
      nde_pc1 = '0;
      nde_ra = '0;
      nde_rb = '0;
      nde_off = '0;
    end else begin
      nde_instr = fd_instr;
      nde_pc1 = fd_pc1;
      nde_ra = gpr[fd_instr[21:19]];
      nde_rb = gpr[fd_instr[18:16]];
      nde_off = {{16{fd_instr[15]}}, fd_instr[15:0]};
    end
    a = de_ra;
    b = de_rb;
    bypass(we_instr, we_wd, de_instr, a, b);
    bypass(mw_instr, mw_wd, de_instr, a, b);
    op = em_instr[24:22];
    if (op == fspc_pkg::OP_ADD || op == fspc_pkg::OP_NOR) bypass(em_instr, em_alu, de_instr, a, b);
    nem_instr = de_instr;
    nem_target = de_pc1 + de_off[15:0];
    nem_rb = b;
    case (de_instr[24:22])
      fspc_pkg::OP_ADD: nem_alu = a + b;
      fspc_pkg::OP_NOR: nem_alu = ~(a | b);
      fspc_pkg::OP_LW, fspc_pkg::OP_SW: nem_alu = a + de_off;
      fspc_pkg::OP_BEQ: nem_alu = a - b;
      default: nem_alu = '0;
    endcase
    nmw_instr = em_instr;
    nmw_wd = mw_wd;
    case (op)
      fspc_pkg::OP_ADD, fspc_pkg::OP_NOR: nmw_wd = em_alu;
      fspc_pkg::OP_LW: nmw_wd = dmem[em_alu[15:0]];
      fspc_pkg::OP_SW: begin
        dmem[em_alu[15:0]] = em_rb;
        r.mw_valid = 1'b1;
        r.mw_addr = em_alu[15:0];
        r.mw_value = em_rb;
      end
      fspc_pkg::OP_BEQ: begin
        if (em_alu == '0) begin
          npc = em_target;
          nfd_instr = fspc_pkg::NOOP_WORD;
          nfd_pc1 = '0;
          nde_instr = fspc_pkg::NOOP_WORD;
          nde_pc1 = '0;
          nde_ra = '0;
          nde_rb = '0;
          nde_off = '0;
          nem_instr = fspc_pkg::NOOP_WORD;
          nem_target = '0;
          nem_alu = '0;
          nem_rb = '0;
        end
      end
      default: ;
    endcase
    if (dest_of(mw_instr, d)) begin
      gpr[d] = mw_wd;
      r.rw_valid = 1'b1;
      r.rw_index = d;
      r.rw_value = mw_wd;
    end
    we_instr = mw_instr;
    we_wd = mw_wd;
    pc = npc;
    fd_instr = nfd_instr;
    fd_pc1 = nfd_pc1;
    de_instr = nde_instr;
    de_pc1 = nde_pc1;
    de_ra = nde_ra;
    de_rb = nde_rb;
    de_off = nde_off;
    em_instr = nem_instr;
    em_target = nem_target;
    em_alu = nem_alu;
    em_rb = nem_rb;
    mw_instr = nmw_instr;
    mw_wd = nmw_wd;
    cycles = cycles + 1;
    if (mw_instr[24:22] == fspc_pkg::OP_HALT) stopped = 1'b1;
    if (mw_instr[24:22] == fspc_pkg::OP_JALR) begin
      stopped = 1'b1;
      faulted = 1'b1;
    end
  endtask

  task automatic predict_request();
    core_status_t r;
    r = '0;
    case (req_type_i)
      fspc_pkg::REQ_LOAD: begin
        imem[addr_i] = data_i;
        dmem[addr_i] = data_i;
      end
      fspc_pkg::REQ_STEP: if (!stopped) advance_pipeline(r);
      fspc_pkg::REQ_READ: r.rd_data = dmem[addr_i];
      default: ;
    endcase
    r.halted = stopped;
    r.fault = faulted;
    r.pc = pc;
    r.cycles = cycles;
    status_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  task automatic check_result();
    core_status_t e;
    if (status_q.size() == 0) begin
      $display("%0t unexpected result with nothing pending", $time);
      fail_count_o++;
      return;
    end
    e = status_q.pop_front();
    check_field("halted", e.halted, halted_o);
    check_field("fault", e.fault, fault_o);
    check_field("pc_now", e.pc, pc_now_o);
    check_field("cycle_count", e.cycles, cycle_count_o);
    check_field("reg_write_valid", e.rw_valid, reg_write_valid_o);
    check_field("reg_write_index", e.rw_index, reg_write_index_o);
    check_field("reg_write_value", e.rw_value, reg_write_value_o);
    check_field("mem_write_valid", e.mw_valid, mem_write_valid_o);
    check_field("mem_write_addr", e.mw_addr, mem_write_addr_o);
    check_field("mem_write_value", e.mw_value, mem_write_value_o);
    check_field("read_data", e.rd_data, read_data_o);
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q.delete();
      for (int i = 0; i < 8; i++) gpr[i] = '0;
      pc = '0;
      fd_instr = fspc_pkg::NOOP_WORD;
      fd_pc1 = '0;
      de_instr = fspc_pkg::NOOP_WORD;
      {de_pc1, de_ra, de_rb, de_off} = '0;
      em_instr = fspc_pkg::NOOP_WORD;
      {em_target, em_alu, em_rb} = '0;
      mw_instr = fspc_pkg::NOOP_WORD;
      mw_wd = '0;
      we_instr = fspc_pkg::NOOP_WORD;
      we_wd = '0;
      cycles = '0;
      stopped = 1'b0;
      faulted = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_result();
      if (in_valid_i && in_ready_o) predict_request();
    end
  end

endmodule

// ===== test/five_stage_pipeline_cpu_core_tb.sv =====
module five_stage_pipeline_cpu_core_tb;

  localparam int PROG_END = 120;
  localparam int DATA_BASE = 65472;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i = fspc_pkg::REQ_LOAD;
  logic [15:0]        addr_i = '0;
  logic signed [31:0] data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               halted_o, fault_o;
  logic [15:0]        pc_now_o;
  logic [31:0]        cycle_count_o;
  logic               reg_write_valid_o;
  logic [2:0]         reg_write_index_o;
  logic signed [31:0] reg_write_value_o;
  logic               mem_write_valid_o;
  logic [15:0]        mem_write_addr_o;
  logic signed [31:0] mem_write_value_o;
  logic signed [31:0] read_data_o;
  int                 fail_count, open_count;
  int                 sent = 0, taken = 0, cycle_no = 0;
  bit                 written [0:65535];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  five_stage_pipeline_cpu_core dut (.*);

  five_stage_pipeline_cpu_core_checker checker_i (
    .fail_count_o(fail_count),
    .open_count_o(open_count),
    .*
  );

  always @(posedge clk_i) begin
    cycle_no++;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] encode(input logic [2:0] op, a, b,
                                         input logic [15:0] low);
    return {7'd0, op, a, b, low};
  endfunction

  function automatic logic [31:0] random_instr(input int at);
    logic [2:0]  a, b;
    logic [15:0] low;
    int          pick, target;
    a = 3'($urandom_range(0, 7));
    b = 3'($urandom_range(0, 7));
    low = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      low[2:0] = 3'($urandom_range(1, 7));
      return {7'($urandom), (pick < 20) ? fspc_pkg::OP_ADD : fspc_pkg::OP_NOR, a, b, low};
    end else if (pick < 60) begin
      return encode(fspc_pkg::OP_LW, 3'd0, 3'($urandom_range(1, 7)),
                    16'($signed($urandom_range(0, 127)) - 64));
    end else if (pick < 75) begin
      return encode(fspc_pkg::OP_SW, 3'd0, b, 16'($signed($urandom_range(0, 127)) - 64));
    end else if (pick < 90) begin
      if ($urandom_range(0, 2) == 0) b = a;
      target = $urandom_range(0, PROG_END - 1);
      return encode(fspc_pkg::OP_BEQ, a, b, 16'(target - at - 1));
    end
    return {7'($urandom), fspc_pkg::NOOP_WORD[24:0]};
  endfunction

  task automatic send_req(input logic [1:0] kind, input logic [15:0] ad,
                          input logic [31:0] dt);
    int gap;
    gap = ((sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = kind;
    addr_i = ad;
    data_i = dt;
    if (kind == fspc_pkg::REQ_LOAD) written[ad] = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = ((taken / 64) % 4 == 1) ? 0 : $urandom_range(0, 10);
      if (taken == 300) hold = 200;
      if (hold > 0) begin
        out_ready_i = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    logic [31:0] word;
    logic [15:0] ad;
    int          pick;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_req(fspc_pkg::REQ_LOAD, 16'(DATA_BASE), 32'h8000_0000);
    send_req(fspc_pkg::REQ_LOAD, 16'(DATA_BASE + 1), 32'h7fff_ffff);
    send_req(fspc_pkg::REQ_LOAD, 16'(DATA_BASE + 2), 32'h0000_0000);
    send_req(fspc_pkg::REQ_LOAD, 16'hffff, 32'hffff_ffff);
    for (int i = DATA_BASE + 3; i < 65535; i++) send_req(fspc_pkg::REQ_LOAD, 16'(i), $urandom);
    send_req(fspc_pkg::REQ_READ, 16'(DATA_BASE), '0);
    send_req(fspc_pkg::REQ_READ, 16'(DATA_BASE + 1), '0);
    send_req(fspc_pkg::REQ_READ, 16'hffff, '0);
    send_req(REQ_UNKNOWN, 16'hffff, 32'hffff_ffff);
    send_req(REQ_UNKNOWN, 16'h0000, 32'h0000_0000);

    // lw feeding a store's data, an add and a nor; taken branch flushing jalr and halt
    send_req(fspc_pkg::REQ_LOAD, 16'd0, encode(fspc_pkg::OP_LW, 3'd0, 3'd1, 16'hffff));
    send_req(fspc_pkg::REQ_LOAD, 16'd1, encode(fspc_pkg::OP_SW, 3'd0, 3'd1, 16'd5));
    send_req(fspc_pkg::REQ_LOAD, 16'd2, encode(fspc_pkg::OP_ADD, 3'd1, 3'd1, 16'd2));
    send_req(fspc_pkg::REQ_LOAD, 16'd3, encode(fspc_pkg::OP_NOR, 3'd2, 3'd1, 16'd3));
    send_req(fspc_pkg::REQ_LOAD, 16'd4, encode(fspc_pkg::OP_BEQ, 3'd0, 3'd0, 16'd2));
    send_req(fspc_pkg::REQ_LOAD, 16'd5, encode(fspc_pkg::OP_JALR, 3'd1, 3'd2, 16'd0));
    send_req(fspc_pkg::REQ_LOAD, 16'd6, encode(fspc_pkg::OP_HALT, 3'd0, 3'd0, 16'd0));
    for (int i = 7; i < PROG_END; i++) send_req(fspc_pkg::REQ_LOAD, 16'(i), random_instr(i));
    word = encode(($urandom_range(0, 1) == 0) ? fspc_pkg::OP_HALT : fspc_pkg::OP_JALR,
                  3'd0, 3'd0, 16'd0);
    send_req(fspc_pkg::REQ_LOAD, 16'(PROG_END), word);
    for (int i = PROG_END + 1; i < 128; i++) begin
      send_req(fspc_pkg::REQ_LOAD, 16'(i), fspc_pkg::NOOP_WORD);
    end
    send_req(fspc_pkg::REQ_READ, 16'd0, '0);

    for (int n = 0; n < 900; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 76) begin
        send_req(fspc_pkg::REQ_STEP, 16'($urandom), $urandom);
      end else if (pick < 86) begin
        send_req(fspc_pkg::REQ_LOAD, 16'($urandom_range(128, DATA_BASE - 1)), $urandom);
      end else if (pick < 96) begin
        ad = 16'($urandom);
        if (!written[ad]) ad = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 127))
                                                          : 16'($urandom_range(DATA_BASE, 65535));
        send_req(fspc_pkg::REQ_READ, ad, $urandom);
      end else begin
        send_req(REQ_UNKNOWN, 16'($urandom), $urandom);
      end
    end
    in_valid_i = 1'b0;

    while (taken != sent) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && open_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
